>>> rtl/gcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller register package
// Shared widths, register word offsets, opcodes, payload types and the
// bank placement helpers of the GPIO controller register block.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int PIN_COUNT     = 54;
    localparam int DATA_W        = 32;
    localparam int OFF_W         = 6;
    localparam int OP_W          = 2;
    localparam int FSEL_W        = 3;
    localparam int PULL_W        = 2;
    localparam int FSEL_PER_WORD = 10;

    typedef logic [PIN_COUNT-1:0] t_pins;
    typedef logic [DATA_W-1:0]    t_word;
    typedef logic [OFF_W-1:0]     t_off;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [FSEL_W-1:0]    t_fsel;
    typedef logic [PULL_W-1:0]    t_pull;

    // Item opcodes.
    localparam t_op OP_READ   = 2'd0;
    localparam t_op OP_WRITE  = 2'd1;
    localparam t_op OP_SAMPLE = 2'd2;

    // Register word offsets.
    localparam t_off OFF_FSEL_LAST = 6'd6;
    localparam t_off OFF_SET0      = 6'd7;
    localparam t_off OFF_SET1      = 6'd8;
    localparam t_off OFF_CLR0      = 6'd10;
    localparam t_off OFF_CLR1      = 6'd11;
    localparam t_off OFF_LEV0      = 6'd13;
    localparam t_off OFF_LEV1      = 6'd14;
    localparam t_off OFF_EDS0      = 6'd16;
    localparam t_off OFF_EDS1      = 6'd17;
    localparam t_off OFF_REN0      = 6'd31;
    localparam t_off OFF_REN1      = 6'd32;
    localparam t_off OFF_FEN0      = 6'd34;
    localparam t_off OFF_FEN1      = 6'd35;
    localparam t_off OFF_PUD       = 6'd37;
    localparam t_off OFF_PUDCLK0   = 6'd38;
    localparam t_off OFF_PUDCLK1   = 6'd39;

    // Field codes.
    localparam t_fsel FSEL_OUTPUT = 3'd1;
    localparam t_pull PULL_DOWN   = 2'd1;
    localparam t_pull PULL_UP     = 2'd2;

    typedef struct packed {
        t_op   opcode;
        t_off  reg_offset;
        t_word write_data;
        t_pins pin_levels;
    } t_item;

    typedef struct packed {
        t_word read_data;
        t_pins pin_drive;
        t_pins pin_output_enable;
        t_pins pull_up_mask;
        t_pins pull_down_mask;
        logic  irq;
    } t_result;

    // Places a 32-bit bank word in the pin vector; absent pins are dropped.
    function automatic t_pins bank_bits(input logic bank, input t_word data);
        logic [2*DATA_W-1:0] wide;
        wide = bank ? {data, {DATA_W{1'b0}}} : {{DATA_W{1'b0}}, data};
        return wide[PIN_COUNT-1:0];
    endfunction

    // Extracts one 32-bit bank word from the pin vector.
    function automatic t_word bank_word(input logic bank, input t_pins v);
        logic [2*DATA_W-1:0] wide;
        wide = (2*DATA_W)'(v);
        return bank ? wide[2*DATA_W-1:DATA_W] : wide[DATA_W-1:0];
    endfunction

endpackage

>>> rtl/gcr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller item channel
// Valid/ready channel carrying bus reads, bus writes and pin-sample ticks.
// ----------------------------------------------------------------------------
interface gcr_in_if;
    logic          valid;
    logic          ready;
    gcr_pkg::t_op  opcode;
    gcr_pkg::t_off reg_offset;
    gcr_pkg::t_word write_data;
    gcr_pkg::t_pins pin_levels;

    modport source (output valid, output opcode, output reg_offset,
                    output write_data, output pin_levels, input ready);
    modport sink   (input valid, input opcode, input reg_offset,
                    input write_data, input pin_levels, output ready);
endinterface

>>> rtl/gcr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller result channel
// Valid/ready channel carrying the read word and the pin-facing outputs.
// ----------------------------------------------------------------------------
interface gcr_out_if;
    logic           valid;
    logic           ready;
    gcr_pkg::t_word read_data;
    gcr_pkg::t_pins pin_drive;
    gcr_pkg::t_pins pin_output_enable;
    gcr_pkg::t_pins pull_up_mask;
    gcr_pkg::t_pins pull_down_mask;
    logic           irq;

    modport source (output valid, output read_data, output pin_drive,
                    output pin_output_enable, output pull_up_mask,
                    output pull_down_mask, output irq, input ready);
    modport sink   (input valid, input read_data, input pin_drive,
                    input pin_output_enable, input pull_up_mask,
                    input pull_down_mask, input irq, output ready);
endinterface

>>> rtl/gcr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller register core
// Holds the controller state, applies one item per accepted transaction and
// forms the result from the state as it stands after the update.
// ----------------------------------------------------------------------------
module gcr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  gcr_pkg::t_item   i_item,
    output gcr_pkg::t_result o_result
);

    gcr_pkg::t_fsel r_fsel [gcr_pkg::PIN_COUNT];
    gcr_pkg::t_fsel n_fsel [gcr_pkg::PIN_COUNT];
    gcr_pkg::t_pull r_pull_state [gcr_pkg::PIN_COUNT];
    gcr_pkg::t_pull n_pull_state [gcr_pkg::PIN_COUNT];
    gcr_pkg::t_pins r_latch, n_latch;
    gcr_pkg::t_pins r_levels, n_levels;
    gcr_pkg::t_pins r_events, n_events;
    gcr_pkg::t_pins r_rise_en, n_rise_en;
    gcr_pkg::t_pins r_fall_en, n_fall_en;
    gcr_pkg::t_pull r_pull_ctl, n_pull_ctl;
    gcr_pkg::t_word rd_word;
    gcr_pkg::t_pins clk_sel;
    logic           is_write;

    // Read mux over the current state.
    always_comb begin
        rd_word = '0;
        if (i_item.reg_offset <= gcr_pkg::OFF_FSEL_LAST) begin
            for (int p = 0; p < gcr_pkg::PIN_COUNT; p++) begin
                if (gcr_pkg::t_off'(p / gcr_pkg::FSEL_PER_WORD) == i_item.reg_offset) begin
                    rd_word[gcr_pkg::FSEL_W*(p % gcr_pkg::FSEL_PER_WORD) +: gcr_pkg::FSEL_W]
                        = r_fsel[p];
                end
            end
        end else begin
            case (i_item.reg_offset)
                gcr_pkg::OFF_LEV0, gcr_pkg::OFF_LEV1: begin
                    rd_word = gcr_pkg::bank_word(i_item.reg_offset == gcr_pkg::OFF_LEV1,
                                                 r_levels);
                end
                gcr_pkg::OFF_EDS0, gcr_pkg::OFF_EDS1: begin
                    rd_word = gcr_pkg::bank_word(i_item.reg_offset == gcr_pkg::OFF_EDS1,
                                                 r_events);
                end
                gcr_pkg::OFF_REN0, gcr_pkg::OFF_REN1: begin
                    rd_word = gcr_pkg::bank_word(i_item.reg_offset == gcr_pkg::OFF_REN1,
                                                 r_rise_en);
                end
                gcr_pkg::OFF_FEN0, gcr_pkg::OFF_FEN1: begin
                    rd_word = gcr_pkg::bank_word(i_item.reg_offset == gcr_pkg::OFF_FEN1,
                                                 r_fall_en);
                end
                gcr_pkg::OFF_PUD: begin
                    rd_word = gcr_pkg::DATA_W'(r_pull_ctl);
                end
                default: begin
                    rd_word = '0;
                end
            endcase
        end
    end

    // Next-state logic.
    always_comb begin
        n_fsel       = r_fsel;
        n_pull_state = r_pull_state;
        n_latch      = r_latch;
        n_levels     = r_levels;
        n_events     = r_events;
        n_rise_en    = r_rise_en;
        n_fall_en    = r_fall_en;
        n_pull_ctl   = r_pull_ctl;
        clk_sel      = '0;
        is_write     = i_accept && (i_item.opcode == gcr_pkg::OP_WRITE);

        if (is_write) begin
            if (i_item.reg_offset <= gcr_pkg::OFF_FSEL_LAST) begin
                for (int p = 0; p < gcr_pkg::PIN_COUNT; p++) begin
                    if (gcr_pkg::t_off'(p / gcr_pkg::FSEL_PER_WORD) == i_item.reg_offset) begin
                        n_fsel[p] = i_item.write_data[gcr_pkg::FSEL_W*(p % gcr_pkg::FSEL_PER_WORD)
                                                      +: gcr_pkg::FSEL_W];
                    end
                end
            end else begin
                case (i_item.reg_offset)
                    gcr_pkg::OFF_SET0, gcr_pkg::OFF_SET1: begin
                        n_latch = r_latch | gcr_pkg::bank_bits(
                            i_item.reg_offset == gcr_pkg::OFF_SET1, i_item.write_data);
                    end
                    gcr_pkg::OFF_CLR0, gcr_pkg::OFF_CLR1: begin
                        n_latch = r_latch & ~gcr_pkg::bank_bits(
                            i_item.reg_offset == gcr_pkg::OFF_CLR1, i_item.write_data);
                    end
                    gcr_pkg::OFF_EDS0, gcr_pkg::OFF_EDS1: begin
                        n_events = r_events & ~gcr_pkg::bank_bits(
                            i_item.reg_offset == gcr_pkg::OFF_EDS1, i_item.write_data);
                    end
                    gcr_pkg::OFF_REN0, gcr_pkg::OFF_REN1: begin
                        n_rise_en = (r_rise_en & ~gcr_pkg::bank_bits(
                                        i_item.reg_offset == gcr_pkg::OFF_REN1, '1))
                                  | gcr_pkg::bank_bits(
                                        i_item.reg_offset == gcr_pkg::OFF_REN1,
                                        i_item.write_data);
                    end
                    gcr_pkg::OFF_FEN0, gcr_pkg::OFF_FEN1: begin
                        n_fall_en = (r_fall_en & ~gcr_pkg::bank_bits(
                                        i_item.reg_offset == gcr_pkg::OFF_FEN1, '1))
                                  | gcr_pkg::bank_bits(
                                        i_item.reg_offset == gcr_pkg::OFF_FEN1,
                                        i_item.write_data);
                    end
                    gcr_pkg::OFF_PUD: begin
                        n_pull_ctl = i_item.write_data[gcr_pkg::PULL_W-1:0];
                    end
                    gcr_pkg::OFF_PUDCLK0, gcr_pkg::OFF_PUDCLK1: begin
                        clk_sel = gcr_pkg::bank_bits(
                            i_item.reg_offset == gcr_pkg::OFF_PUDCLK1, i_item.write_data);
                    end
                    default: begin
                        n_latch = r_latch;
                    end
                endcase
            end
        end else if (i_accept && (i_item.opcode == gcr_pkg::OP_SAMPLE)) begin
            n_events = r_events
                     | (i_item.pin_levels & ~r_levels & r_rise_en)
                     | (~i_item.pin_levels & r_levels & r_fall_en);
            n_levels = i_item.pin_levels;
        end

        // The pull clock latches the control value held before this item.
        for (int p = 0; p < gcr_pkg::PIN_COUNT; p++) begin
            if (clk_sel[p]) begin
                n_pull_state[p] = r_pull_ctl;
            end
        end
    end

    // Result from the updated state.
    always_comb begin
        o_result.read_data = (i_item.opcode == gcr_pkg::OP_READ) ? rd_word : '0;
        o_result.pin_drive = n_latch;
        o_result.irq       = |n_events;
        for (int p = 0; p < gcr_pkg::PIN_COUNT; p++) begin
            o_result.pin_output_enable[p] = (n_fsel[p] == gcr_pkg::FSEL_OUTPUT);
            o_result.pull_up_mask[p]      = (n_pull_state[p] == gcr_pkg::PULL_UP);
            o_result.pull_down_mask[p]    = (n_pull_state[p] == gcr_pkg::PULL_DOWN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < gcr_pkg::PIN_COUNT; p++) begin
                r_fsel[p]       <= '0;
                r_pull_state[p] <= '0;
            end
            r_latch    <= '0;
            r_levels   <= '0;
            r_events   <= '0;
            r_rise_en  <= '0;
            r_fall_en  <= '0;
            r_pull_ctl <= '0;
        end else begin
            r_fsel       <= n_fsel;
            r_pull_state <= n_pull_state;
            r_latch      <= n_latch;
            r_levels     <= n_levels;
            r_events     <= n_events;
            r_rise_en    <= n_rise_en;
            r_fall_en    <= n_fall_en;
            r_pull_ctl   <= n_pull_ctl;
        end
    end

endmodule

>>> rtl/gcr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller result buffer
// Two-entry result register that decouples the item side from a stalled
// result receiver.
// ----------------------------------------------------------------------------
module gcr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gcr_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output gcr_pkg::t_result o_data
);

    gcr_pkg::t_result r_data [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != 2'd0);
    assign o_ready = (r_count != 2'd2);
    assign o_data  = r_data[r_rd_ptr];
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/gpio_controller_regs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller register block, top level
// Register model of a 54-pin general-purpose I/O controller with a
// valid/ready item channel and a valid/ready result channel.
// ----------------------------------------------------------------------------
// Usage:
// The item channel i_in carries one transaction per bus read, bus write or
// pin-sample tick. Every accepted item yields exactly one result transaction
// on o_res with the read word (zero unless the item was a read of a mapped,
// readable word) and the pin-facing outputs after the item took effect.
// The result of an accepted item is registered in the result buffer and is
// offered on o_res once all earlier results have been taken. Throughput is
// one item per cycle while the result buffer has a free entry; the state
// update is registered logic, and the rate is set by the two-entry result buffer in front of o_res.
// When the receiver stalls, the buffer keeps taking items until both of its
// entries hold results; i_in.ready then drops until a result is taken.
// Results leave in acceptance order and are never dropped or repeated.
// Reset (i_rst_n low at a clock edge) puts all pins to input, clears the
// output latch, levels, events, edge enables and pull settings, and
// empties the result buffer.
// ----------------------------------------------------------------------------
module gpio_controller_regs_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcr_in_if.sink    i_in,
    gcr_out_if.source o_res
);

    gcr_pkg::t_item   item;
    gcr_pkg::t_result core_result;
    gcr_pkg::t_result buf_result;
    logic             buf_ready;
    logic             accept;

    assign item.opcode     = i_in.opcode;
    assign item.reg_offset = i_in.reg_offset;
    assign item.write_data = i_in.write_data;
    assign item.pin_levels = i_in.pin_levels;

    // An item is taken whenever the result buffer has a free entry.
    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;

    gcr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_result (core_result)
    );

    gcr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (core_result),
        .o_ready     (buf_ready),
        .o_valid     (o_res.valid),
        .i_pop_ready (o_res.ready),
        .o_data      (buf_result)
    );

    assign o_res.read_data         = buf_result.read_data;
    assign o_res.pin_drive         = buf_result.pin_drive;
    assign o_res.pin_output_enable = buf_result.pin_output_enable;
    assign o_res.pull_up_mask      = buf_result.pull_up_mask;
    assign o_res.pull_down_mask    = buf_result.pull_down_mask;
    assign o_res.irq               = buf_result.irq;

    // No result is offered in the cycle after a reset edge.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result offered right after reset");

    // Back-pressure on the item side only when a result is pending.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_res.valid)
        else $error("item channel stalled with an empty result buffer");

    // A non-read item into an empty buffer shows up next with a zero read word.
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !o_res.valid && i_in.opcode != gcr_pkg::OP_READ)
        |=> (o_res.valid && o_res.read_data == '0))
        else $error("non-read item gave a nonzero read word");

    // A result held back by the receiver stays on o_res unchanged.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(buf_result)))
        else $error("stalled result changed or vanished");

endmodule

>>> tb/gpio_controller_regs_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller register block testbench
// Drives bus reads, bus writes and pin-sample ticks into the item channel.
// A cycle-free model of the register map predicts every result, and each
// result transaction is compared field by field in acceptance order.
// Both channels idle at random, with one stretch of full throughput.
// ----------------------------------------------------------------------------
module gpio_controller_regs_top_test;
    import gcr_pkg::*;

    // Codes the package does not name.
    localparam t_op  OP_NONE      = 2'd3;   // fourth opcode, has no effect
    localparam t_off OFF_FSEL0    = 6'd0;
    localparam t_off OFF_UNMAPPED = 6'd63;
    localparam t_word ALL_ONES    = 32'hFFFF_FFFF;
    // Function select value 1 in all ten fields of a select word.
    localparam t_word FSEL_ALL_OUTPUT = 32'h0924_9249;

    localparam int RANDOM_ITEMS = 1325;
    localparam int DRAIN_EVERY  = 337;
    localparam int IDLE_PCT     = 30;
    localparam int MAX_PRINTS   = 200;

    typedef struct {
        t_item item;
        bit    drain;   // hold this item back until all results are in
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gcr_in_if  item_bus ();
    gcr_out_if result_bus ();

    gpio_controller_regs_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_bus),
        .o_res   (result_bus)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Register map model. It holds its own copy of every piece of state and
    // is advanced once per accepted item transaction.
    // ------------------------------------------------------------------------
    t_fsel fsel_q [PIN_COUNT] = '{default: '0};
    t_pull pull_q [PIN_COUNT] = '{default: '0};
    t_pins latch_q   = '0;
    t_pins levels_q  = '0;
    t_pins events_q  = '0;
    t_pins rise_en_q = '0;
    t_pins fall_en_q = '0;
    t_pull pull_ctl_q = '0;

    // Places a bank word on the pin vector; pins past the last one drop off.
    function automatic t_pins bank_place(input bit upper, input t_word w);
        logic [63:0] wide;
        wide = {32'h0, w} << (upper ? 32 : 0);
        return wide[PIN_COUNT-1:0];
    endfunction

    function automatic t_word bank_pick(input bit upper, input t_pins v);
        logic [63:0] wide;
        wide = 64'(v) >> (upper ? 32 : 0);
        return wide[31:0];
    endfunction

    function automatic t_word reg_read(input t_off off);
        t_word w;
        int    p;
        w = '0;
        if (off <= OFF_FSEL_LAST) begin
            // Ten 3-bit fields per word; bits 30 and 31 stay zero.
            for (int k = 0; k < FSEL_PER_WORD; k++) begin
                p = int'(off) * FSEL_PER_WORD + k;
                if (p < PIN_COUNT) w[3*k +: 3] = fsel_q[p];
            end
            return w;
        end
        case (off)
            OFF_LEV0, OFF_LEV1: w = bank_pick(off == OFF_LEV1, levels_q);
            OFF_EDS0, OFF_EDS1: w = bank_pick(off == OFF_EDS1, events_q);
            OFF_REN0, OFF_REN1: w = bank_pick(off == OFF_REN1, rise_en_q);
            OFF_FEN0, OFF_FEN1: w = bank_pick(off == OFF_FEN1, fall_en_q);
            OFF_PUD:            w = t_word'(pull_ctl_q);
            default:            w = '0;
        endcase
        return w;
    endfunction

    function automatic void reg_write(input t_off off, input t_word data);
        t_pins bits;
        t_pins bank;
        int    p;
        if (off <= OFF_FSEL_LAST) begin
            for (int k = 0; k < FSEL_PER_WORD; k++) begin
                p = int'(off) * FSEL_PER_WORD + k;
                if (p < PIN_COUNT) fsel_q[p] = data[3*k +: 3];
            end
            return;
        end
        case (off)
            OFF_SET0, OFF_SET1: latch_q |= bank_place(off == OFF_SET1, data);
            OFF_CLR0, OFF_CLR1: latch_q &= ~bank_place(off == OFF_CLR1, data);
            OFF_EDS0, OFF_EDS1: events_q &= ~bank_place(off == OFF_EDS1, data);
            OFF_REN0, OFF_REN1: begin
                bank      = bank_place(off == OFF_REN1, ALL_ONES);
                bits      = bank_place(off == OFF_REN1, data);
                rise_en_q = (rise_en_q & ~bank) | bits;
            end
            OFF_FEN0, OFF_FEN1: begin
                bank      = bank_place(off == OFF_FEN1, ALL_ONES);
                bits      = bank_place(off == OFF_FEN1, data);
                fall_en_q = (fall_en_q & ~bank) | bits;
            end
            OFF_PUD: pull_ctl_q = data[PULL_W-1:0];
            OFF_PUDCLK0, OFF_PUDCLK1: begin
                // Every pin whose bit is written as one takes the pull code.
                bits = bank_place(off == OFF_PUDCLK1, data);
                for (int q = 0; q < PIN_COUNT; q++)
                    if (bits[q]) pull_q[q] = pull_ctl_q;
            end
            default: ;
        endcase
    endfunction

    // Applies one item and returns the result the block must produce for it.
    function automatic t_result gpio_predict(input t_item it);
        t_result r;
        r = '0;
        case (it.opcode)
            OP_READ:  r.read_data = reg_read(it.reg_offset);
            OP_WRITE: reg_write(it.reg_offset, it.write_data);
            OP_SAMPLE: begin
                events_q |= (it.pin_levels & ~levels_q & rise_en_q)
                          | (~it.pin_levels & levels_q & fall_en_q);
                levels_q = it.pin_levels;
            end
            default: ;
        endcase
        r.pin_drive = latch_q;
        for (int p = 0; p < PIN_COUNT; p++) begin
            r.pin_output_enable[p] = (fsel_q[p] == FSEL_OUTPUT);
            r.pull_up_mask[p]      = (pull_q[p] == PULL_UP);
            r.pull_down_mask[p]    = (pull_q[p] == PULL_DOWN);
        end
        r.irq = |events_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------------
    t_pending pending_items [$];
    t_result  predicted_results [$];

    // Mapped words other than the function select words.
    t_off reg_words [15] = '{OFF_SET0, OFF_SET1, OFF_CLR0, OFF_CLR1, OFF_LEV0,
                             OFF_LEV1, OFF_EDS0, OFF_EDS1, OFF_REN0, OFF_REN1,
                             OFF_FEN0, OFF_FEN1, OFF_PUD, OFF_PUDCLK0,
                             OFF_PUDCLK1};

    // Pin levels evolve from tick to tick so that edges stay sparse enough
    // for event bits to be set, read back and cleared.
    t_pins stim_levels = '0;

    task automatic queue_item(input t_op op, input t_off off, input t_word data,
                              input t_pins levels, input bit drain);
        t_pending entry;
        entry.item.opcode     = op;
        entry.item.reg_offset = off;
        entry.item.write_data = data;
        entry.item.pin_levels = levels;
        entry.drain           = drain;
        pending_items.push_back(entry);
    endtask

    function automatic t_item random_gpio_item();
        t_item it;
        int    roll;
        roll = $urandom_range(99);
        it.opcode = (roll < 35) ? OP_READ :
                    (roll < 75) ? OP_WRITE :
                    (roll < 95) ? OP_SAMPLE : OP_NONE;
        // Mostly mapped words, with some fully random offsets on top.
        roll = $urandom_range(99);
        if (roll < 30)
            it.reg_offset = t_off'($urandom_range(OFF_FSEL_LAST));
        else if (roll < 88)
            it.reg_offset = reg_words[$urandom_range(14)];
        else
            it.reg_offset = t_off'($urandom);
        roll = $urandom_range(99);
        it.write_data = (roll < 10) ? '0 : (roll < 20) ? ALL_ONES : t_word'($urandom);
        roll = $urandom_range(99);
        if (roll < 50) begin
            for (int n = $urandom_range(1, 3); n > 0; n--)
                stim_levels[$urandom_range(PIN_COUNT-1)] ^= 1'b1;
        end else if (roll < 80) begin
            stim_levels = t_pins'({$urandom, $urandom});
        end else begin
            stim_levels = (roll < 90) ? '0 : '1;
        end
        it.pin_levels = stim_levels;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. It presents the next pending item when the channel is free, unless
    // it idles at random or a drain marker holds the item back, and predicts the
    // result of each item at the edge it is accepted on.
    int  sent_count;
    int  read_count;
    int  write_count;
    int  sample_count;
    int  noop_count;
    int  checked_count;
    int  irq_count;
    int  fail_count;
    wire steady = (sent_count >= 500) && (sent_count < 850);

    always @(posedge i_clk) begin : drive
        t_item got;
        bit    hold_off;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                got.opcode     = item_bus.opcode;
                got.reg_offset = item_bus.reg_offset;
                got.write_data = item_bus.write_data;
                got.pin_levels = item_bus.pin_levels;
                predicted_results.push_back(gpio_predict(got));
                sent_count++;
                case (got.opcode)
                    OP_READ:   read_count++;
                    OP_WRITE:  write_count++;
                    OP_SAMPLE: sample_count++;
                    default:   noop_count++;
                endcase
            end
            if (!item_bus.valid || item_bus.ready) begin
                hold_off = (pending_items.size() == 0) ||
                           (!steady && ($urandom_range(99) < IDLE_PCT));
                // A drain marker holds the item back until nothing is owed.
                if (!hold_off && pending_items[0].drain && predicted_results.size() != 0)
                    hold_off = 1'b1;
                if (hold_off) begin
                    item_bus.valid <= 1'b0;
                end else begin
                    item_bus.valid      <= 1'b1;
                    item_bus.opcode     <= pending_items[0].item.opcode;
                    item_bus.reg_offset <= pending_items[0].item.reg_offset;
                    item_bus.write_data <= pending_items[0].item.write_data;
                    item_bus.pin_levels <= pending_items[0].item.pin_levels;
                    void'(pending_items.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result transaction is matched against the oldest
    // prediction; the receiver stalls at random outside the steady stretch.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("%0t: result %0d: %s is %h, expected %h",
                     $realtime, checked_count, what, got, want);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (result_bus.valid && result_bus.ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with no item owed", '0, '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (result_bus.read_data !== want.read_data)
                        report_mismatch("read_data", 64'(result_bus.read_data),
                                        64'(want.read_data));
                    if (result_bus.pin_drive !== want.pin_drive)
                        report_mismatch("pin_drive", 64'(result_bus.pin_drive),
                                        64'(want.pin_drive));
                    if (result_bus.pin_output_enable !== want.pin_output_enable)
                        report_mismatch("pin_output_enable",
                                        64'(result_bus.pin_output_enable),
                                        64'(want.pin_output_enable));
                    if (result_bus.pull_up_mask !== want.pull_up_mask)
                        report_mismatch("pull_up_mask", 64'(result_bus.pull_up_mask),
                                        64'(want.pull_up_mask));
                    if (result_bus.pull_down_mask !== want.pull_down_mask)
                        report_mismatch("pull_down_mask", 64'(result_bus.pull_down_mask),
                                        64'(want.pull_down_mask));
                    if (result_bus.irq !== want.irq)
                        report_mismatch("irq", 64'(result_bus.irq), 64'(want.irq));
                    if (want.irq) irq_count++;
                end
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed items, random items, then drain.
    // ------------------------------------------------------------------------
    initial begin : main
        t_item it;
        item_bus.valid      = 1'b0;
        item_bus.opcode     = OP_READ;
        item_bus.reg_offset = '0;
        item_bus.write_data = '0;
        item_bus.pin_levels = '0;
        result_bus.ready    = 1'b0;

        // Directed part. Select word five covers pins 50..53 only, and the
        // last select word covers no pin at all.
        queue_item(OP_WRITE, OFF_FSEL_LAST - 6'd1, ALL_ONES, '0, 1'b0);
        queue_item(OP_READ,  OFF_FSEL_LAST - 6'd1, '0, '0, 1'b0);
        queue_item(OP_WRITE, OFF_FSEL_LAST, ALL_ONES, '0, 1'b0);
        queue_item(OP_READ,  OFF_FSEL_LAST, '0, '0, 1'b0);
        queue_item(OP_WRITE, OFF_FSEL0, FSEL_ALL_OUTPUT, '0, 1'b0);
        // Output latch set and clear in both banks, absent pins included;
        // the set word itself reads back as zero.
        queue_item(OP_WRITE, OFF_SET0, ALL_ONES, '0, 1'b0);
        queue_item(OP_WRITE, OFF_SET1, ALL_ONES, '0, 1'b0);
        queue_item(OP_READ,  OFF_SET0, '0, '0, 1'b0);
        queue_item(OP_WRITE, OFF_CLR0, 32'h0000_FFFF, '0, 1'b0);
        queue_item(OP_WRITE, OFF_CLR1, ALL_ONES, '0, 1'b0);
        // Edges: rising on bank 0, falling on bank 1.
        queue_item(OP_WRITE, OFF_REN0, ALL_ONES, '0, 1'b0);
        queue_item(OP_WRITE, OFF_FEN1, ALL_ONES, '0, 1'b0);
        queue_item(OP_READ,  OFF_FEN1, '0, '0, 1'b0);
        queue_item(OP_SAMPLE, OFF_FSEL0, '0, '1, 1'b0);
        queue_item(OP_READ,  OFF_EDS0, '0, '0, 1'b0);
        queue_item(OP_SAMPLE, OFF_FSEL0, '0, '0, 1'b0);
        queue_item(OP_READ,  OFF_EDS1, '0, '0, 1'b0);
        queue_item(OP_WRITE, OFF_EDS0, ALL_ONES, '0, 1'b0);
        queue_item(OP_WRITE, OFF_EDS1, ALL_ONES, '0, 1'b0);
        // Level words ignore writes.
        queue_item(OP_WRITE, OFF_LEV0, ALL_ONES, '0, 1'b0);
        // Pull code three latches but shows in neither mask; then pull-up.
        queue_item(OP_WRITE, OFF_PUD, ALL_ONES, '0, 1'b0);
        queue_item(OP_WRITE, OFF_PUDCLK0, ALL_ONES, '0, 1'b0);
        queue_item(OP_WRITE, OFF_PUD, t_word'(PULL_UP), '0, 1'b0);
        queue_item(OP_WRITE, OFF_PUDCLK1, ALL_ONES, '0, 1'b0);
        queue_item(OP_READ,  OFF_UNMAPPED, '0, '0, 1'b0);
        queue_item(OP_WRITE, OFF_UNMAPPED, ALL_ONES, '0, 1'b0);
        queue_item(OP_NONE,  OFF_PUD, ALL_ONES, '1, 1'b0);

        // Random part. Every so often the sender waits for the block to
        // deliver every result it owes before it goes on.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it = random_gpio_item();
            queue_item(it.opcode, it.reg_offset, it.write_data, it.pin_levels,
                       (n % DRAIN_EVERY) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_bus.valid || predicted_results.size() != 0)
            @(posedge i_clk);
        // The extra edges catch any stray result.
        repeat (5) @(posedge i_clk);

        $display("Run covered %0d reads, %0d writes, %0d sample ticks and %0d no-op items.",
                 read_count, write_count, sample_count, noop_count);
        $display("%0d results checked, %0d with the interrupt raised, %0d mismatches.",
                 checked_count, irq_count, fail_count);
        if (fail_count == 0) begin
            $display("gpio_controller_regs_top_test OK");
        end else begin
            $display("gpio_controller_regs_top_test NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial begin : watchdog
        #2_000_000;
        $display("Timed out with %0d items pending and %0d results owed.",
                 pending_items.size(), predicted_results.size());
        $display("gpio_controller_regs_top_test NOT OK");
        $finish;
    end

endmodule
